FILE: hdl/abr_pkg.sv
// Shared types and constants for the alternating-bit receiver datagram checker.
// No dependencies; every other file refers to this package by scoped names.
package abr_pkg;

    // Bytes per datagram that are counted and checked; later bytes pass through.
    localparam int MAX_BYTES = 512;
    localparam int IDX_W     = $clog2(MAX_BYTES + 1);
    localparam int LEN_W     = 16;
    localparam int SEQ_W     = 32;
    localparam int SUM_W     = 16;

    // Header layout
    localparam int HDR_BYTES  = 12;
    localparam int LEN_HI_IDX = 2;
    localparam int LEN_LO_IDX = 3;
    localparam int SEQ_FIRST  = 8;
    localparam int SEQ_LAST   = 11;

    localparam logic [SUM_W-1:0] SUM_GOOD    = 16'hFFFF;
    localparam logic [SUM_W-1:0] ACK_CK_BASE = 16'h0C00;

    // Depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_SHORT     = 2'd1,
        VERDICT_BAD_SUM   = 2'd2,
        VERDICT_WRONG_SEQ = 2'd3
    } t_verdict;

    // One classified byte, handed from the front to the back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last;      // final byte of the datagram
        logic       active;    // index below MAX_BYTES, byte is counted
        logic       odd;       // index is odd: completes a checksum word
        logic       seq_cap;   // byte belongs to the sequence number
        logic       payload;   // byte lies in the payload region
        logic       cnt_ge12;  // count after this byte covers the header
        logic       cnt_odd;   // count after this byte is odd
    } t_item;

    // One result word
    typedef struct packed {
        logic [SUM_W-1:0] ack_checksum;
        logic             ack_number;
        logic             ack_send;
        t_verdict         verdict;
        logic             final_flag;
        logic             payload_flag;
        logic [7:0]       out_byte;
    } t_result;

endpackage

FILE: hdl/abr_front.sv
// Front part of the receiver: counts bytes, captures the length field and
// classifies each byte. Depends on abr_pkg.
module abr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output abr_pkg::t_item o_item
);

    logic [abr_pkg::IDX_W-1:0] r_index, n_index;
    logic [abr_pkg::LEN_W-1:0] r_len, n_len;
    logic                      active;
    logic                      is_len;

    assign active = (r_index < abr_pkg::IDX_W'(abr_pkg::MAX_BYTES));
    assign is_len = active && ((r_index == abr_pkg::IDX_W'(abr_pkg::LEN_HI_IDX)) ||
                               (r_index == abr_pkg::IDX_W'(abr_pkg::LEN_LO_IDX)));

    always_comb begin
        n_index = active ? r_index + abr_pkg::IDX_W'(1) : r_index;
        n_len   = is_len ? {r_len[abr_pkg::LEN_W-9:0], i_byte} : r_len;
    end

    always_comb begin
        o_item.rx_byte  = i_byte;
        o_item.last     = i_last;
        o_item.active   = active;
        o_item.odd      = r_index[0];
        o_item.seq_cap  = active && (r_index >= abr_pkg::IDX_W'(abr_pkg::SEQ_FIRST)) &&
                          (r_index <= abr_pkg::IDX_W'(abr_pkg::SEQ_LAST));
        o_item.payload  = active && (r_index >= abr_pkg::IDX_W'(abr_pkg::HDR_BYTES)) &&
                          (abr_pkg::LEN_W'(r_index) < r_len);
        o_item.cnt_ge12 = (n_index >= abr_pkg::IDX_W'(abr_pkg::HDR_BYTES));
        o_item.cnt_odd  = n_index[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_len   <= '0;
        end else if (i_push) begin
            // restart the count and header capture after the final byte
            if (i_last) begin
                r_index <= '0;
                r_len   <= '0;
            end else begin
                r_index <= n_index;
                r_len   <= n_len;
            end
        end
    end

endmodule

FILE: hdl/abr_queue.sv
// Short queue of classified bytes between the front and the back.
// Depends on abr_pkg.
module abr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  abr_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output abr_pkg::t_item o_item
);

    abr_pkg::t_item                r_mem [abr_pkg::QUEUE_DEPTH];
    logic [abr_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [abr_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [abr_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == abr_pkg::QCNT_W'(abr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == abr_pkg::QPTR_W'(abr_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + abr_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == abr_pkg::QPTR_W'(abr_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + abr_pkg::QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + abr_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - abr_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/abr_back.sv
// Back part of the receiver: checksum, sequence capture, verdict and the
// output register. Depends on abr_pkg.
module abr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  abr_pkg::t_item   i_item,
    output logic             o_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output abr_pkg::t_result o_result
);

    function automatic logic [abr_pkg::SUM_W-1:0] fold_add(
        input logic [abr_pkg::SUM_W-1:0] acc,
        input logic [abr_pkg::SUM_W-1:0] word
    );
        logic [abr_pkg::SUM_W:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[abr_pkg::SUM_W-1:0] + abr_pkg::SUM_W'(s[abr_pkg::SUM_W]);
    endfunction

    logic [abr_pkg::SUM_W-1:0] r_sum;
    logic [7:0]                r_hold;
    logic [abr_pkg::SEQ_W-1:0] r_seq;
    logic                      r_exp;
    logic                      r_out_valid;
    abr_pkg::t_result          r_result;

    logic                      pair;
    logic                      add_word;
    logic [7:0]                hold_eff;
    logic [abr_pkg::SUM_W-1:0] word;
    logic [abr_pkg::SUM_W-1:0] sum_fin;
    logic [abr_pkg::SEQ_W-1:0] seq_eff;
    abr_pkg::t_verdict         verdict;
    abr_pkg::t_result          n_result;

    assign o_pop       = i_item_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        pair     = i_item.active && i_item.odd;
        hold_eff = (i_item.active && !i_item.odd) ? i_item.rx_byte : r_hold;
        // a completed pair, or on the final byte the padded odd leftover
        word     = pair ? {i_item.rx_byte, r_hold} : {8'd0, hold_eff};
        add_word = pair || (i_item.last && i_item.cnt_odd);
        sum_fin  = add_word ? fold_add(r_sum, word) : r_sum;
        seq_eff  = i_item.seq_cap ? {r_seq[abr_pkg::SEQ_W-9:0], i_item.rx_byte} : r_seq;

        priority if (!i_item.cnt_ge12) begin
            verdict = abr_pkg::VERDICT_SHORT;
        end else if (sum_fin != abr_pkg::SUM_GOOD) begin
            verdict = abr_pkg::VERDICT_BAD_SUM;
        end else if (seq_eff != abr_pkg::SEQ_W'(r_exp)) begin
            verdict = abr_pkg::VERDICT_WRONG_SEQ;
        end else begin
            verdict = abr_pkg::VERDICT_ACCEPT;
        end

        n_result              = '0;
        n_result.out_byte     = i_item.rx_byte;
        n_result.payload_flag = i_item.payload;
        n_result.final_flag   = i_item.last;
        if (i_item.last) begin
            n_result.verdict = verdict;
            if (verdict == abr_pkg::VERDICT_ACCEPT) begin
                n_result.ack_send     = 1'b1;
                n_result.ack_number   = r_exp;
                n_result.ack_checksum = ~(abr_pkg::ACK_CK_BASE + {7'd0, r_exp, 8'd0});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_hold      <= '0;
            r_seq       <= '0;
            r_exp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (o_pop) begin
                if (i_item.last) begin
                    r_sum  <= '0;
                    r_hold <= '0;
                    r_seq  <= '0;
                    if (verdict == abr_pkg::VERDICT_ACCEPT) begin
                        r_exp <= ~r_exp;
                    end
                end else begin
                    r_sum  <= sum_fin;
                    r_hold <= hold_eff;
                    r_seq  <= seq_eff;
                end
            end
        end
    end

endmodule

FILE: hdl/alternating_bit_receiver.sv
// Top level of the alternating-bit receiver datagram checker.
// Depends on abr_pkg, abr_front, abr_queue and abr_back.
//
// Receives datagram bytes one word per cycle on the slave stream, tlast on the
// final byte, and echoes every byte on the master stream. tuser marks payload
// bytes (index 12 up to the length field at bytes 2-3, big-endian). On the
// final byte the result carries a verdict: accepted, too short (under 12
// counted bytes, checked first), bad ones' complement checksum (16-bit words,
// low byte first, odd length padded with zero), or wrong sequence (bytes 8-11,
// big-endian, against the expected bit). On acceptance the expected bit
// toggles and the result requests an ack with its number and checksum. Only
// the first MAX_BYTES bytes (512) are counted; later bytes are echoed as
// non-payload. The block takes one byte per cycle while the output is not
// stalled; an accepted byte is written into the queue, and the back then
// moves it into the output register, whose word is shown on the master stream.
// The front classifies bytes, a two-entry queue decouples it from the back,
// and the back holds the checksum accumulator and the output register, so
// input tready drops only after the output has stalled with the queue full.
module alternating_bit_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_s_axis_tlast,   // end_of_datagram
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] out_byte, [9:8] verdict, [10] ack_send,
                                          // [11] ack_number, [27:12] ack_checksum, rest 0
    output logic        o_m_axis_tuser,   // payload_flag
    output logic        o_m_axis_tlast    // final_flag
);

    abr_pkg::t_item   front_item;
    abr_pkg::t_item   q_item;
    abr_pkg::t_result result;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;

    // accept a word whenever the queue has room
    assign o_s_axis_tready = !q_full;
    assign push            = i_s_axis_tvalid && !q_full;

    abr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_item  (front_item)
    );

    abr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    abr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (pop),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_result     (result)
    );

    // pack the result word, zero-fill to whole bytes
    assign o_m_axis_tdata = {4'd0, result.ack_checksum, result.ack_number, result.ack_send,
                             result.verdict, result.out_byte};
    assign o_m_axis_tuser = result.payload_flag;
    assign o_m_axis_tlast = result.final_flag;

`ifndef SYNTH
    // an ack is requested only on an accepted final byte
    a_ack_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && result.ack_send |->
            result.final_flag && (result.verdict == abr_pkg::VERDICT_ACCEPT))
        else $error("ack requested without an accepted final byte");

    // non-final words carry no verdict and no ack
    a_quiet_midstream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !result.final_flag |->
            (result.verdict == abr_pkg::VERDICT_ACCEPT) && !result.ack_send &&
            (result.ack_checksum == '0))
        else $error("verdict or ack on a non-final word");

    // the input stalls only behind a stalled output
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled while output register empty");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for alternating_bit_receiver: directed header cases,
// then random datagrams. Predicts every echoed word and verdict in-bench;
// depends only on abr_pkg and the RTL.

module testbench;

    localparam int RUN_LIMIT     = 600000;  // cycles before the run is declared hung
    localparam int RANDOM_WORDS  = 1300;
    localparam int REPORT_MAX    = 10;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CK_LO_IDX     = 4;       // where the bench places the checksum word
    localparam int CK_HI_IDX     = 5;
    localparam int DIRECTED_ROWS = 25;

    typedef enum int {
        FR_GOOD,
        FR_WRONG_SEQ,
        FR_BAD_SUM,
        FR_SHORT,
        FR_NOISE,
        FR_OVERLONG
    } t_frame_kind;

    // One directed word; typed rows carry the result written out by hand
    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic               typed;
        abr_pkg::t_verdict  verdict;
        logic               ack_send;
        logic               ack_number;
        logic [15:0]        ack_checksum;
    } t_directed_row;

    // A 12-byte ack-shaped header with sequence 0 and length 12. Sent once it is
    // accepted; replayed right after a one-byte runt it is a duplicate and must
    // be refused as out of sequence.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{8'hFF, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h0C, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'hF3, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b1, 1'b1, abr_pkg::VERDICT_ACCEPT,    1'b1, 1'b0, 16'hF3FF},
        '{8'hFF, 1'b1, 1'b1, abr_pkg::VERDICT_SHORT,     1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h0C, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'hF3, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, abr_pkg::VERDICT_ACCEPT,    1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b1, 1'b1, abr_pkg::VERDICT_WRONG_SEQ, 1'b0, 1'b0, 16'h0000}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Receive-side state of the bench's own checker
    logic [15:0]               rx_sum        = '0;
    logic [abr_pkg::IDX_W-1:0] rx_index      = '0;
    logic [7:0]                rx_hold       = '0;
    logic [15:0]               rx_len        = '0;
    logic [31:0]               rx_seq        = '0;
    logic                      rx_expect_bit = 1'b0;

    abr_pkg::t_result rx_expected [$];  // predicted output words, oldest first

    int    fail_count   = 0;
    int    words_sent   = 0;
    int    frames_done  = 0;
    int    verdict_seen [4] = '{0, 0, 0, 0};
    int    cycle_count  = 0;
    int    stall_left   = 0;
    logic  calm         = 1'b0;  // stretches with no gaps and no stalls

    alternating_bit_receiver uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End-around-carry add of two 16-bit words
    function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic string describe(abr_pkg::t_result r);
        return $sformatf("byte %h pay %b fin %b verdict %0d ack %b num %b ck %h",
                         r.out_byte, r.payload_flag, r.final_flag, r.verdict,
                         r.ack_send, r.ack_number, r.ack_checksum);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("%s", msg);
    endtask

    // Advance the checker by one received byte and return the word it must echo
    function automatic abr_pkg::t_result advance_rx(logic [7:0] d, logic last);
        abr_pkg::t_result r;
        logic [15:0]      total;
        r = '0;
        r.out_byte   = d;
        r.final_flag = last;
        r.verdict    = abr_pkg::VERDICT_ACCEPT;
        // bytes past the limit are echoed but leave the datagram state alone
        if (rx_index < abr_pkg::MAX_BYTES) begin
            if (!rx_index[0]) rx_hold = d;
            else rx_sum = ones_add(rx_sum, {d, rx_hold});
            if (rx_index == abr_pkg::LEN_HI_IDX || rx_index == abr_pkg::LEN_LO_IDX)
                rx_len = {rx_len[7:0], d};
            if (rx_index >= abr_pkg::SEQ_FIRST && rx_index <= abr_pkg::SEQ_LAST)
                rx_seq = {rx_seq[23:0], d};
            if (rx_index >= abr_pkg::HDR_BYTES && rx_index < rx_len) r.payload_flag = 1'b1;
            rx_index = rx_index + 1'b1;
        end
        if (last) begin
            // an odd count leaves one byte waiting: pad it with a zero high half
            total = rx_sum;
            if (rx_index[0]) total = ones_add(total, {8'h00, rx_hold});
            if (rx_index < abr_pkg::HDR_BYTES) r.verdict = abr_pkg::VERDICT_SHORT;
            else if (total != abr_pkg::SUM_GOOD) r.verdict = abr_pkg::VERDICT_BAD_SUM;
            else if (rx_seq != {31'b0, rx_expect_bit}) r.verdict = abr_pkg::VERDICT_WRONG_SEQ;
            else begin
                r.ack_send     = 1'b1;
                r.ack_number   = rx_expect_bit;
                r.ack_checksum = ~(abr_pkg::ACK_CK_BASE +
                                   (rx_expect_bit ? 16'h0100 : 16'h0000));
                rx_expect_bit  = ~rx_expect_bit;
            end
            verdict_seen[r.verdict]++;
            frames_done++;
            rx_sum   = '0;
            rx_index = '0;
            rx_hold  = '0;
            rx_len   = '0;
            rx_seq   = '0;
        end
        return r;
    endfunction

    // Offer one byte after a random gap, hold it until the block takes it,
    // then predict the word it must produce
    task automatic transfer_byte(input logic [7:0] d, input logic last,
                                 output abr_pkg::t_result predicted);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        predicted = advance_rx(d, last);
        words_sent++;
    endtask

    // Cycle budget, and switching between calm and noisy stretches
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (cycle_count == RUN_LIMIT) begin
            $display("Run hung: %0d words still awaited after %0d cycles",
                     rx_expected.size(), cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: check each word taken, then decide the next cycle's tready
    always @(posedge clk) begin
        abr_pkg::t_result want;
        abr_pkg::t_result got;
        if (rst_n && m_tvalid === 1'b1 && m_tready) begin
            got.out_byte     = m_tdata[7:0];
            got.payload_flag = m_tuser;
            got.final_flag   = m_tlast;
            got.verdict      = abr_pkg::t_verdict'(m_tdata[9:8]);
            got.ack_send     = m_tdata[10];
            got.ack_number   = m_tdata[11];
            got.ack_checksum = m_tdata[27:12];
            if (rx_expected.size() == 0) begin
                note_failure($sformatf("Unexpected word at cycle %0d: %s",
                                       cycle_count, describe(got)));
            end else begin
                want = rx_expected.pop_front();
                if (got.out_byte !== want.out_byte ||
                    got.payload_flag !== want.payload_flag ||
                    got.final_flag !== want.final_flag || got.verdict !== want.verdict ||
                    got.ack_send !== want.ack_send || got.ack_number !== want.ack_number ||
                    got.ack_checksum !== want.ack_checksum || m_tdata[31:28] !== 4'h0) begin
                    note_failure($sformatf(
                        "Mismatch at cycle %0d\n  expected %s\n  actual   %s pad %h",
                        cycle_count, describe(want), describe(got), m_tdata[31:28]));
                end
            end
        end
        // hold tready low through a stall, else raise it and maybe start one
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    initial begin : stimulus
        abr_pkg::t_result pred;
        t_directed_row    row;
        t_frame_kind      kind;
        logic [7:0]       frame [$];
        logic [15:0]      len_word;
        logic [31:0]      seq_word;
        logic [15:0]      acc;
        logic [7:0]       hold;
        int               random_words;
        int               frame_no;
        int               n;
        int               lim;
        int               r;
        int               pos;
        random_words = 0;
        frame_no     = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: typed rows override the prediction with the hand value
        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            row = directed_rows[k];
            transfer_byte(row.data, row.last, pred);
            if (row.typed) begin
                pred.out_byte     = row.data;
                pred.payload_flag = 1'b0;
                pred.final_flag   = row.last;
                pred.verdict      = row.verdict;
                pred.ack_send     = row.ack_send;
                pred.ack_number   = row.ack_number;
                pred.ack_checksum = row.ack_checksum;
            end
            rx_expected.push_back(pred);
        end

        // Random part: mostly well-formed datagrams with random content. The first
        // three are fixed: one near or past the byte limit, one of odd length, one corrupted.
        while (random_words < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (frame_no == 0) kind = FR_OVERLONG;
            else if (frame_no == 1) kind = FR_GOOD;
            else if (frame_no == 2) kind = FR_BAD_SUM;
            else if (r < 58) kind = FR_GOOD;
            else if (r < 70) kind = FR_WRONG_SEQ;
            else if (r < 82) kind = FR_BAD_SUM;
            else if (r < 90) kind = FR_SHORT;
            else if (r < 98) kind = FR_NOISE;
            else kind = FR_OVERLONG;

            case (kind)
                FR_SHORT:    n = $urandom_range(1, abr_pkg::HDR_BYTES - 1);
                FR_NOISE:    n = $urandom_range(1, 40);
                FR_OVERLONG: n = $urandom_range(abr_pkg::MAX_BYTES - 1,
                                                abr_pkg::MAX_BYTES + 20);
                default:     n = $urandom_range(abr_pkg::HDR_BYTES, 64);
            endcase
            if (frame_no == 1) n = n | 1;

            frame.delete();
            repeat (n) frame.push_back(8'($urandom));

            if (kind != FR_SHORT && kind != FR_NOISE) begin
                // length field: usually honest, sometimes off or at its extremes
                r = $urandom_range(0, 99);
                if (r < 65) len_word = 16'(n);
                else if (r < 80) len_word = 16'($urandom_range(0, n + 8));
                else if (r < 88) len_word = 16'h0000;
                else if (r < 94) len_word = 16'hFFFF;
                else len_word = 16'($urandom);
                frame[abr_pkg::LEN_HI_IDX] = len_word[15:8];
                frame[abr_pkg::LEN_LO_IDX] = len_word[7:0];

                seq_word = {31'b0, rx_expect_bit};
                if (kind == FR_WRONG_SEQ) begin
                    seq_word = $urandom();
                    if ($urandom_range(0, 1)) seq_word = {31'b0, ~rx_expect_bit};
                    if (seq_word == {31'b0, rx_expect_bit}) seq_word[0] = ~seq_word[0];
                end
                for (int k = 0; k < 4; k++)
                    frame[abr_pkg::SEQ_FIRST + k] = seq_word[31 - 8*k -: 8];

                // fill the checksum word so the counted bytes fold to all ones
                frame[CK_LO_IDX] = 8'h00;
                frame[CK_HI_IDX] = 8'h00;
                acc = '0;
                hold = '0;
                lim = (n < abr_pkg::MAX_BYTES) ? n : abr_pkg::MAX_BYTES;
                for (int k = 0; k < lim; k++) begin
                    if (k % 2 == 0) hold = frame[k];
                    else acc = ones_add(acc, {frame[k], hold});
                end
                if (lim % 2) acc = ones_add(acc, {8'h00, hold});
                frame[CK_LO_IDX] = ~acc[7:0];
                frame[CK_HI_IDX] = ~acc[15:8];

                if (kind == FR_BAD_SUM) begin
                    pos = $urandom_range(0, lim - 1);
                    frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
                end
            end

            foreach (frame[k]) begin
                transfer_byte(frame[k], k == frame.size() - 1, pred);
                rx_expected.push_back(pred);
            end
            random_words += n;
            frame_no++;
        end
        s_tvalid <= 1'b0;

        // drain, then give stray words time to show up
        while (rx_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d datagrams: %0d accepted, %0d runts,",
                 words_sent, frames_done, verdict_seen[abr_pkg::VERDICT_ACCEPT],
                 verdict_seen[abr_pkg::VERDICT_SHORT]);
        $display("%0d bad sums, %0d out of sequence; %0d failures counted",
                 verdict_seen[abr_pkg::VERDICT_BAD_SUM],
                 verdict_seen[abr_pkg::VERDICT_WRONG_SEQ], fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/abr_pkg.sv
hdl/abr_front.sv
hdl/abr_queue.sv
hdl/abr_back.sv
hdl/alternating_bit_receiver.sv
dv/testbench.sv
